// ----- rtl/core/sope_pkg.sv -----
`default_nettype none

package sope_pkg;

   localparam int DEF_Q_WIDTH       = 24;
   localparam int DEF_D_WIDTH       = 24;
   localparam int DEF_CORDIC_STAGES = 24;

   localparam int THR_WIDTH = 29;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 29'd268435;

   localparam int QUEUE_DEPTH = 4;
   localparam int VAL_WIDTH   = 32;
   localparam int QUOT_WIDTH  = 30;

   localparam int CW = 34;
   typedef logic signed [CW-1:0] cword_type;

   localparam cword_type ONE_Q30       = 34'sd1073741824;
   localparam cword_type TWO_PI_S      = 34'sd1686629713;
   localparam cword_type HALF_TURN_Q28 = 34'sd843314856;
   localparam cword_type PI_Q28        = 34'sd843314857;
   localparam cword_type HALF_PI_Q28   = 34'sd421657428;
   localparam cword_type CORDIC_GAIN   = 34'sd652032874;

   localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

   // ceil(2^34 / 3) and ceil(2^36 / 15)
   localparam logic [32:0] RECIP_3  = 33'd5726623062;
   localparam logic [32:0] RECIP_15 = 33'd4581298450;

   typedef struct packed {
      logic valid;
      logic ser;
   } sope_tag_type;

   function automatic cword_type atan_q30(input logic [4:0] idx);
      cword_type v;
      case (idx)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         5'd24: v = 34'sd64;
         5'd25: v = 34'sd32;
         5'd26: v = 34'sd16;
         5'd27: v = 34'sd8;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         5'd30: v = 34'sd1;
         5'd31: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sinc_of_product_evaluator.sv -----
// throughput: one transfer per cycle while rsp_ready does not stall the output,
//    set by the fully pipelined reduction, cordic and divider stages;
//    a four-entry queue decouples front and back
// reset: synchronous, clears all valid bits and the queue, threshold to 268435
`default_nettype none

module sinc_of_product_evaluator
   import sope_pkg::*;
#(
   parameter int Q_WIDTH       = DEF_Q_WIDTH,
   parameter int D_WIDTH       = DEF_D_WIDTH,
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [Q_WIDTH-1:0]          req_q_value,
   input  logic [D_WIDTH-1:0]          req_d_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [VAL_WIDTH-1:0] rsp_sinc_value,
   output logic                        rsp_series_used,
   input  logic                        csr_wr_en,
   input  logic [THR_WIDTH-1:0]        csr_wr_data
);
   localparam int XW = Q_WIDTH + D_WIDTH;

   logic                        push_valid;
   logic                        push_ready;
   logic [XW-1:0]               push_x;
   logic                        push_ser;
   logic                        head_valid;
   logic [XW:0]                 head_data;
   logic                        back_en;
   logic                        pop;
   sope_tag_type                head_tag;
   sope_tag_type                ser_tag;
   logic [XW-1:0]               ser_x;
   logic signed [VAL_WIDTH-1:0] ser_sval;
   sope_tag_type                trig_tag;
   logic [XW-1:0]               trig_x;
   logic signed [VAL_WIDTH-1:0] trig_sval;
   cword_type                   trig_sine;

   assign back_en  = !rsp_valid || rsp_ready;
   assign pop      = back_en && head_valid;
   assign head_tag = '{valid: head_valid, ser: head_data[0]};

   sope_front #(
      .Q_WIDTH (Q_WIDTH),
      .D_WIDTH (D_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_q_value (req_q_value),
      .req_d_value (req_d_value),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_x      (push_x),
      .push_ser    (push_ser)
   );

   sope_queue #(
      .WIDTH (XW + 1)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_x, push_ser}),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   sope_series #(
      .X_WIDTH (XW)
   ) u_series (
      .clock    (clock),
      .reset    (reset),
      .en       (back_en),
      .in_tag   (head_tag),
      .in_x     (head_data[XW:1]),
      .out_tag  (ser_tag),
      .out_x    (ser_x),
      .out_sval (ser_sval)
   );

   sope_trig #(
      .X_WIDTH       (XW),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_trig (
      .clock    (clock),
      .reset    (reset),
      .en       (back_en),
      .in_tag   (ser_tag),
      .in_x     (ser_x),
      .in_sval  (ser_sval),
      .out_tag  (trig_tag),
      .out_x    (trig_x),
      .out_sval (trig_sval),
      .out_sine (trig_sine)
   );

   sope_div #(
      .X_WIDTH (XW)
   ) u_div (
      .clock           (clock),
      .reset           (reset),
      .en              (back_en),
      .in_tag          (trig_tag),
      .in_x            (trig_x),
      .in_sval         (trig_sval),
      .in_sine         (trig_sine),
      .rsp_valid       (rsp_valid),
      .rsp_sinc_value  (rsp_sinc_value),
      .rsp_series_used (rsp_series_used)
   );

`ifndef SYNTH
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sinc_value <= 32'sd1073741824)
                    && (rsp_sinc_value >= -32'sd1073741824))
      else $error("result outside unit range");

   a_series_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_series_used) |-> (rsp_sinc_value > 32'sd0))
      else $error("series result not positive");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sope_front.sv -----
`default_nettype none

module sope_front
   import sope_pkg::*;
#(
   parameter int Q_WIDTH = DEF_Q_WIDTH,
   parameter int D_WIDTH = DEF_D_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [Q_WIDTH-1:0]         req_q_value,
   input  logic [D_WIDTH-1:0]         req_d_value,
   input  logic                       csr_wr_en,
   input  logic [THR_WIDTH-1:0]       csr_wr_data,
   input  logic                       push_ready,
   output logic                       push_valid,
   output logic [Q_WIDTH+D_WIDTH-1:0] push_x,
   output logic                       push_ser
);
   localparam int XW = Q_WIDTH + D_WIDTH;
   localparam int CMP_WIDTH = (XW > THR_WIDTH) ? XW : THR_WIDTH;

   logic                 stage_en;
   logic                 v1_ff;
   logic                 v2_ff;
   logic [Q_WIDTH-1:0]   q_ff;
   logic [D_WIDTH-1:0]   d_ff;
   logic [XW-1:0]        x_ff;
   logic [XW-1:0]        x_in;
   logic [THR_WIDTH-1:0] thr_ff;

   assign stage_en  = !v2_ff || push_ready;
   assign req_ready = stage_en;
   assign x_in      = XW'(q_ff) * XW'(d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         thr_ff <= THR_RESET;
      end else begin
         if (stage_en) begin
            v1_ff <= req_valid;
            v2_ff <= v1_ff;
         end
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         q_ff <= req_q_value;
         d_ff <= req_d_value;
         x_ff <= x_in;
      end
   end

   // zero product always takes the series
   assign push_valid = v2_ff;
   assign push_x     = x_ff;
   assign push_ser   = (x_ff == '0) || (CMP_WIDTH'(x_ff) < CMP_WIDTH'(thr_ff));

endmodule

`default_nettype wire

// ----- rtl/core/sope_queue.sv -----
`default_nettype none

module sope_queue
   import sope_pkg::*;
#(
   parameter int WIDTH = DEF_Q_WIDTH + DEF_D_WIDTH + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = push_valid && push_ready;
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sope_series.sv -----
`default_nettype none

module sope_series
   import sope_pkg::*;
#(
   parameter int X_WIDTH = DEF_Q_WIDTH + DEF_D_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  sope_tag_type                in_tag,
   input  logic [X_WIDTH-1:0]          in_x,
   output sope_tag_type                out_tag,
   output logic [X_WIDTH-1:0]          out_x,
   output logic signed [VAL_WIDTH-1:0] out_sval
);
   sope_tag_type tag0_ff, tag1_ff, tag2_ff, tag3_ff;
   logic [X_WIDTH-1:0] x0_ff, x1_ff, x2r_ff, x3_ff;

   logic [THR_WIDTH-1:0] xs;
   logic [57:0] p1_ff;
   logic [58:0] p1_round;
   logic [31:0] sq;
   logic [32:0] n3_sum;
   logic [63:0] p2a_ff;
   logic [64:0] p2b_ff;
   logic [63:0] p2a_round;
   logic [33:0] qd;
   logic [34:0] n15_sum;
   logic [30:0] t1_ff;
   logic [64:0] p3_ff;
   logic [28:0] t2;
   cword_type   sum;
   cword_type   sum_clamped;
   logic signed [VAL_WIDTH-1:0] sval_ff;

   assign xs        = THR_WIDTH'(in_x);
   assign p1_round  = {1'b0, p1_ff} + 59'd33554432;
   assign sq        = p1_round[57:26];
   assign n3_sum    = {1'b0, sq} + 33'd3;
   assign p2a_round = p2a_ff + 64'd536870912;
   assign qd        = p2a_round[63:30];
   assign n15_sum   = {1'b0, qd} + 35'd60;
   assign t2        = p3_ff[64:36];

   always_comb begin
      sum = ONE_Q30 - $signed({3'b000, t1_ff}) + $signed({5'b00000, t2});
      if (sum > ONE_Q30) begin
         sum_clamped = ONE_Q30;
      end else if (sum < -ONE_Q30) begin
         sum_clamped = -ONE_Q30;
      end else begin
         sum_clamped = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else if (en) begin
         tag0_ff <= in_tag;
         tag1_ff <= tag0_ff;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff   <= in_x;
         x1_ff   <= x0_ff;
         x2r_ff  <= x1_ff;
         x3_ff   <= x2r_ff;
         p1_ff   <= 58'(xs) * 58'(xs);
         p2a_ff  <= 64'(sq) * 64'(sq);
         p2b_ff  <= 65'(n3_sum[32:1]) * 65'(RECIP_3);
         t1_ff   <= p2b_ff[64:34];
         p3_ff   <= 65'(n15_sum[34:3]) * 65'(RECIP_15);
         sval_ff <= VAL_WIDTH'(sum_clamped);
      end
   end

   assign out_tag  = tag3_ff;
   assign out_x    = x3_ff;
   assign out_sval = sval_ff;

endmodule

`default_nettype wire

// ----- rtl/core/sope_trig.sv -----
`default_nettype none

module sope_trig
   import sope_pkg::*;
#(
   parameter int X_WIDTH       = DEF_Q_WIDTH + DEF_D_WIDTH,
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  sope_tag_type                in_tag,
   input  logic [X_WIDTH-1:0]          in_x,
   input  logic signed [VAL_WIDTH-1:0] in_sval,
   output sope_tag_type                out_tag,
   output logic [X_WIDTH-1:0]          out_x,
   output logic signed [VAL_WIDTH-1:0] out_sval,
   output cword_type                   out_sine
);
   localparam int HI_W = (X_WIDTH > 30) ? X_WIDTH - 30 : 1;
   localparam int PW   = 2 * HI_W;
   localparam int QCW  = HI_W + 31;
   localparam logic [HI_W-1:0] RECIP_2PI =
      HI_W'((128'd1 << (30 + HI_W)) / 128'(TWO_PI_Q28));
   localparam logic [32:0] TWO_PI_33  = 33'(TWO_PI_Q28);
   localparam logic [32:0] FOUR_PI_33 = 33'(TWO_PI_Q28) << 1;

   // reduction modulo two pi: reciprocal estimate of the quotient,
   // then the remainder is below three turns and two corrections finish it
   sope_tag_type                m0_tag_ff, m1_tag_ff, m2_tag_ff, m3_tag_ff;
   logic [X_WIDTH-1:0]          m0_x_ff, m1_x_ff, m2_x_ff, m3_x_ff;
   logic signed [VAL_WIDTH-1:0] m0_sval_ff, m1_sval_ff, m2_sval_ff, m3_sval_ff;
   logic [HI_W-1:0]             x_hi;
   logic [PW-1:0]               qe_prod;
   logic [HI_W-1:0]             qe_ff;
   logic [QCW-1:0]              qc_ff;
   logic [32:0]                 r_diff;
   logic [32:0]                 r2_ff;
   logic [30:0]                 r3_ff;

   assign x_hi    = HI_W'(in_x >> 30);
   assign qe_prod = PW'(x_hi) * PW'(RECIP_2PI);
   assign r_diff  = 33'(m1_x_ff) - 33'(qc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m0_tag_ff <= '0;
         m1_tag_ff <= '0;
         m2_tag_ff <= '0;
         m3_tag_ff <= '0;
      end else if (en) begin
         m0_tag_ff <= in_tag;
         m1_tag_ff <= m0_tag_ff;
         m2_tag_ff <= m1_tag_ff;
         m3_tag_ff <= m2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m0_x_ff    <= in_x;
         m1_x_ff    <= m0_x_ff;
         m2_x_ff    <= m1_x_ff;
         m3_x_ff    <= m2_x_ff;
         m0_sval_ff <= in_sval;
         m1_sval_ff <= m0_sval_ff;
         m2_sval_ff <= m1_sval_ff;
         m3_sval_ff <= m2_sval_ff;
         qe_ff      <= HI_W'(qe_prod >> HI_W);
         qc_ff      <= QCW'(qe_ff) * QCW'(TWO_PI_Q28);
         r2_ff      <= (r_diff >= FOUR_PI_33) ? r_diff - FOUR_PI_33 : r_diff;
         r3_ff      <= (r2_ff >= TWO_PI_33) ? 31'(r2_ff - TWO_PI_33) : 31'(r2_ff);
      end
   end

   // fold into [-pi/2, pi/2]
   sope_tag_type                ftag_ff;
   logic [X_WIDTH-1:0]          fx_ff;
   logic signed [VAL_WIDTH-1:0] fsval_ff;
   cword_type                   fz_ff;
   cword_type                   r0;
   cword_type                   r1;
   cword_type                   r2;

   always_comb begin
      r0 = $signed({3'b000, r3_ff});
      r1 = (r0 > HALF_TURN_Q28) ? r0 - TWO_PI_S : r0;
      if (r1 > HALF_PI_Q28) begin
         r2 = PI_Q28 - r1;
      end else if (r1 < -HALF_PI_Q28) begin
         r2 = -PI_Q28 - r1;
      end else begin
         r2 = r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ftag_ff <= '0;
      end else if (en) begin
         ftag_ff <= m3_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx_ff    <= m3_x_ff;
         fsval_ff <= m3_sval_ff;
         fz_ff    <= r2 <<< 2;
      end
   end

   // rotation cordic, one stage per iteration
   sope_tag_type                ctag_ff  [CORDIC_STAGES];
   logic [X_WIDTH-1:0]          cx_ff    [CORDIC_STAGES];
   logic signed [VAL_WIDTH-1:0] csval_ff [CORDIC_STAGES];
   cword_type                   cc_ff    [CORDIC_STAGES];
   cword_type                   cs_ff    [CORDIC_STAGES];
   cword_type                   cz_ff    [CORDIC_STAGES];

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      localparam cword_type ATAN = atan_q30(5'(g));
      sope_tag_type                tag_src;
      logic [X_WIDTH-1:0]          x_src;
      logic signed [VAL_WIDTH-1:0] sval_src;
      cword_type                   c_src;
      cword_type                   s_src;
      cword_type                   z_src;
      cword_type                   c_sh;
      cword_type                   s_sh;
      if (g == 0) begin : g_head
         assign tag_src  = ftag_ff;
         assign x_src    = fx_ff;
         assign sval_src = fsval_ff;
         assign c_src    = CORDIC_GAIN;
         assign s_src    = '0;
         assign z_src    = fz_ff;
      end else begin : g_body
         assign tag_src  = ctag_ff[g-1];
         assign x_src    = cx_ff[g-1];
         assign sval_src = csval_ff[g-1];
         assign c_src    = cc_ff[g-1];
         assign s_src    = cs_ff[g-1];
         assign z_src    = cz_ff[g-1];
      end
      assign c_sh = c_src >>> g;
      assign s_sh = s_src >>> g;
      always_ff @(posedge clock) begin
         if (reset) begin
            ctag_ff[g] <= '0;
         end else if (en) begin
            ctag_ff[g] <= tag_src;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[g]    <= x_src;
            csval_ff[g] <= sval_src;
            if (z_src >= 0) begin
               cc_ff[g] <= c_src - s_sh;
               cs_ff[g] <= s_src + c_sh;
               cz_ff[g] <= z_src - ATAN;
            end else begin
               cc_ff[g] <= c_src + s_sh;
               cs_ff[g] <= s_src - c_sh;
               cz_ff[g] <= z_src + ATAN;
            end
         end
      end
   end

   assign out_tag  = ctag_ff[CORDIC_STAGES-1];
   assign out_x    = cx_ff[CORDIC_STAGES-1];
   assign out_sval = csval_ff[CORDIC_STAGES-1];
   assign out_sine = cs_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/sope_div.sv -----
`default_nettype none

module sope_div
   import sope_pkg::*;
#(
   parameter int X_WIDTH = DEF_Q_WIDTH + DEF_D_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  sope_tag_type                in_tag,
   input  logic [X_WIDTH-1:0]          in_x,
   input  logic signed [VAL_WIDTH-1:0] in_sval,
   input  cword_type                   in_sine,
   output logic                        rsp_valid,
   output logic signed [VAL_WIDTH-1:0] rsp_sinc_value,
   output logic                        rsp_series_used
);
   localparam int DW = ((X_WIDTH > 59) ? X_WIDTH : 59) + 31;

   // dividend: |sine| in Q.58 plus half the divisor for rounding
   cword_type   s_cl;
   logic        s_neg;
   logic [30:0] s_mag;

   always_comb begin
      if (in_sine > ONE_Q30) begin
         s_cl = ONE_Q30;
      end else if (in_sine < -ONE_Q30) begin
         s_cl = -ONE_Q30;
      end else begin
         s_cl = in_sine;
      end
      s_neg = (s_cl < 0);
      s_mag = s_neg ? 31'(-s_cl) : 31'(s_cl);
   end

   sope_tag_type                d0_tag_ff;
   logic [X_WIDTH-1:0]          d0_x_ff;
   logic signed [VAL_WIDTH-1:0] d0_sval_ff;
   logic                        d0_neg_ff;
   logic [DW-1:0]               d0_n_ff;

   sope_tag_type                d1_tag_ff;
   logic [X_WIDTH-1:0]          d1_x_ff;
   logic signed [VAL_WIDTH-1:0] d1_sval_ff;
   logic                        d1_neg_ff;
   logic                        d1_sat_ff;
   logic [DW-1:0]               d1_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_tag_ff <= '0;
         d1_tag_ff <= '0;
      end else if (en) begin
         d0_tag_ff <= in_tag;
         d1_tag_ff <= d0_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_x_ff    <= in_x;
         d0_sval_ff <= in_sval;
         d0_neg_ff  <= s_neg;
         d0_n_ff    <= (DW'(s_mag) << 28) + DW'(in_x >> 1);
         d1_x_ff    <= d0_x_ff;
         d1_sval_ff <= d0_sval_ff;
         d1_neg_ff  <= d0_neg_ff;
         d1_sat_ff  <= (d0_n_ff >= (DW'(d0_x_ff) << QUOT_WIDTH));
         d1_rem_ff  <= d0_n_ff;
      end
   end

   // restoring division, one quotient bit per stage
   sope_tag_type                qtag_ff  [QUOT_WIDTH];
   logic [X_WIDTH-1:0]          qx_ff    [QUOT_WIDTH];
   logic signed [VAL_WIDTH-1:0] qsval_ff [QUOT_WIDTH];
   logic                        qneg_ff  [QUOT_WIDTH];
   logic                        qsat_ff  [QUOT_WIDTH];
   logic [DW-1:0]               qrem_ff  [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0]       quo_ff   [QUOT_WIDTH];

   for (genvar g = 0; g < QUOT_WIDTH; g++) begin : g_div
      sope_tag_type                tag_src;
      logic [X_WIDTH-1:0]          x_src;
      logic signed [VAL_WIDTH-1:0] sval_src;
      logic                        neg_src;
      logic                        sat_src;
      logic [DW-1:0]               rem_src;
      logic [QUOT_WIDTH-1:0]       quo_src;
      logic [DW-1:0]               sub;
      logic                        fits;
      if (g == 0) begin : g_head
         assign tag_src  = d1_tag_ff;
         assign x_src    = d1_x_ff;
         assign sval_src = d1_sval_ff;
         assign neg_src  = d1_neg_ff;
         assign sat_src  = d1_sat_ff;
         assign rem_src  = d1_rem_ff;
         assign quo_src  = '0;
      end else begin : g_body
         assign tag_src  = qtag_ff[g-1];
         assign x_src    = qx_ff[g-1];
         assign sval_src = qsval_ff[g-1];
         assign neg_src  = qneg_ff[g-1];
         assign sat_src  = qsat_ff[g-1];
         assign rem_src  = qrem_ff[g-1];
         assign quo_src  = quo_ff[g-1];
      end
      assign sub  = DW'(x_src) << (QUOT_WIDTH - 1 - g);
      assign fits = (rem_src >= sub);
      always_ff @(posedge clock) begin
         if (reset) begin
            qtag_ff[g] <= '0;
         end else if (en) begin
            qtag_ff[g] <= tag_src;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            qx_ff[g]    <= x_src;
            qsval_ff[g] <= sval_src;
            qneg_ff[g]  <= neg_src;
            qsat_ff[g]  <= sat_src;
            qrem_ff[g]  <= fits ? rem_src - sub : rem_src;
            quo_ff[g]   <= {quo_src[QUOT_WIDTH-2:0], fits};
         end
      end
   end

   sope_tag_type           last_tag;
   logic [VAL_WIDTH-1:0]   mag;
   logic [VAL_WIDTH-1:0]   val_in;
   logic                   rsp_valid_ff;
   logic [VAL_WIDTH-1:0]   val_ff;
   logic                   ser_ff;

   assign last_tag = qtag_ff[QUOT_WIDTH-1];
   assign mag      = qsat_ff[QUOT_WIDTH-1] ? VAL_WIDTH'(ONE_Q30)
                                           : VAL_WIDTH'(quo_ff[QUOT_WIDTH-1]);

   always_comb begin
      if (last_tag.ser) begin
         val_in = qsval_ff[QUOT_WIDTH-1];
      end else if (qneg_ff[QUOT_WIDTH-1]) begin
         val_in = -mag;
      end else begin
         val_in = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= last_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff <= val_in;
         ser_ff <= last_tag.ser;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sinc_value  = $signed(val_ff);
   assign rsp_series_used = ser_ff;

endmodule

`default_nettype wire
